// ----- rtl/rcn_pkg.sv -----
package rcn_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned SumW        = 10;
  localparam int unsigned NumW        = 16;
  localparam int unsigned QuotW       = 8;
  localparam int unsigned NumLanes    = 3;
  localparam int unsigned FullScale   = 255;
  localparam int unsigned CutoffReset = 64;

  typedef struct packed {
    logic [ChanW-1:0] chan0_in;
    logic [ChanW-1:0] chan1_in;
    logic [ChanW-1:0] chan2_in;
  } pix_t;

  typedef struct packed {
    logic [ChanW-1:0] chan0_out;
    logic [ChanW-1:0] chan1_out;
    logic [ChanW-1:0] chan2_out;
  } res_t;

  // Sideband that travels alongside the lanes
  typedef struct packed {
    logic valid;
    logic black;
  } ctl_t;

endpackage

// ----- rtl/rcn_lane.sv -----
module rcn_lane (
  input  logic                       clk_i,
  input  logic [rcn_pkg::ChanW-1:0]  chan_i,
  input  logic [rcn_pkg::SumW-1:0]   sum_i,
  output logic [rcn_pkg::ChanW-1:0]  norm_o
);
  import rcn_pkg::*;

  localparam int unsigned ShW = NumW + 2;

  logic [NumW-1:0]  rem_q [QuotW];
  logic [SumW-1:0]  div_q [QuotW];
  logic [QuotW-1:0] quo_q [QuotW];

  logic [NumW-1:0] num;

  // 255*c as (c << 8) - c
  assign num = {chan_i, {ChanW{1'b0}}} - NumW'(chan_i);

  // Restoring divider, one quotient bit per stage, MSB first.
  // 255*c < 256*sum, so eight bits cover the quotient.
  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [NumW-1:0]  rem_in;
    logic [SumW-1:0]  div_in;
    logic [QuotW-1:0] quo_in;
    logic [ShW-1:0]   div_sh;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign div_in = sum_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign div_sh = ShW'(div_in) << (QuotW - 1 - k);
    assign take   = {2'b00, rem_in} >= div_sh;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? rem_in - div_sh[NumW-1:0] : rem_in;
      div_q[k] <= div_in;
      quo_q[k] <= quo_in | (QuotW'(take) << (QuotW - 1 - k));
    end
  end

  // Round half to even, then cap
  logic [SumW:0]   rem2;
  logic            up;
  logic [QuotW:0]  rounded;

  assign rem2    = {rem_q[QuotW-1][SumW-1:0], 1'b0};
  assign up      = (rem2 > {1'b0, div_q[QuotW-1]}) ||
                   ((rem2 == {1'b0, div_q[QuotW-1]}) && quo_q[QuotW-1][0]);
  assign rounded = {1'b0, quo_q[QuotW-1]} + (QuotW+1)'(up);
  assign norm_o  = rounded[QuotW] ? ChanW'(FullScale) : rounded[ChanW-1:0];

endmodule

// ----- rtl/rcn_merge.sv -----
module rcn_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rcn_pkg::ctl_t             ctl_i,
  input  logic [rcn_pkg::ChanW-1:0] norm_i [rcn_pkg::NumLanes],
  output logic                      valid_o,
  output rcn_pkg::res_t             res_o
);
  import rcn_pkg::*;

  logic valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  // Black pixel overrides all lanes
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      res_q.chan0_out <= ctl_i.black ? '0 : norm_i[0];
      res_q.chan1_out <= ctl_i.black ? '0 : norm_i[1];
      res_q.chan2_out <= ctl_i.black ? '0 : norm_i[2];
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/rgb_chromaticity_normalize_unit.sv -----
// Pipeline: one input stage, eight divider stages, one output stage; a pixel
//   accepted at the input stage is then on res_o, with valid_o high.
// Throughput: one pixel per clock; busy is never raised.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_ni low, async): pipeline valids cleared, cutoff register back to 64.
module rgb_chromaticity_normalize_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rcn_pkg::pix_t              pix_i,
  input  logic                       cfg_we_i,
  input  logic [rcn_pkg::SumW-1:0]   cfg_data_i,
  output logic                       valid_o,
  output rcn_pkg::res_t              res_o
);
  import rcn_pkg::*;

  // Sideband depth: input stage plus one per divider stage
  localparam int unsigned Depth = QuotW + 1;

  // Every channel share is 255/3 when all three channels match
  localparam logic [ChanW-1:0] EqualShare = ChanW'(FullScale / NumLanes);

  logic                accept;
  logic [SumW-1:0]     cutoff_q;
  logic [SumW-1:0]     sum_d, sum_q;
  logic [ChanW-1:0]    chan_q [NumLanes];
  logic                vld_q  [Depth];
  logic                blk_q  [Depth];
  logic [ChanW-1:0]    norm   [NumLanes];
  ctl_t                ctl;

  // Fully pipelined: never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Black cutoff register: write only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= SumW'(CutoffReset);
    end else if (cfg_we_i) begin
      cutoff_q <= cfg_data_i;
    end
  end

  // Input stage: channel sum and black decision, both settled before the lanes
  assign sum_d = SumW'(pix_i.chan0_in) + SumW'(pix_i.chan1_in) + SumW'(pix_i.chan2_in);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q[0] <= pix_i.chan0_in;
      chan_q[1] <= pix_i.chan1_in;
      chan_q[2] <= pix_i.chan2_in;
      sum_q     <= sum_d;
    end
  end

  // Sideband follows the lanes stage by stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < Depth; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Sum zero is always black, so a lane's divide by zero never reaches the output
  always_ff @(posedge clk_i) begin
    blk_q[0] <= sum_d <= cutoff_q;
    for (int i = 1; i < Depth; i++) begin
      blk_q[i] <= blk_q[i-1];
    end
  end

  // One divider lane per color channel, all sharing the same sum
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rcn_lane u_lane (
      .clk_i  (clk_i),
      .chan_i (chan_q[l]),
      .sum_i  (sum_q),
      .norm_o (norm[l])
    );
  end

  assign ctl.valid = vld_q[Depth-1];
  assign ctl.black = blk_q[Depth-1];

  // Output register: applies black override and raises the strobe
  rcn_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .norm_i  (norm),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // Each result strobe traces back to one accepted transaction
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, Depth + 1))
    else $error("result strobe without matching transaction");

  // A pixel judged black leaves as all zeros
  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(vld_q[0] && blk_q[0], Depth) |-> (valid_o && res_o == '0))
    else $error("black pixel produced nonzero output");

  // Gray input, not black: every channel becomes one third of full scale
  a_gray_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(vld_q[0] && !blk_q[0] && chan_q[0] == chan_q[1] && chan_q[1] == chan_q[2],
          Depth)
    |-> (valid_o && res_o.chan0_out == EqualShare && res_o.chan1_out == EqualShare &&
         res_o.chan2_out == EqualShare))
    else $error("gray pixel not normalized to equal shares");

endmodule
